@@ rtl/fss_pkg.sv @@
`timescale 1ns / 1ps

package fss_pkg;

  // command codes of the input channel
  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_NAME   = 2'd2
  } fss_cmd_e;

  // scoring constants
  localparam logic [5:0]  HIT_POINTS   = 6'd10;
  localparam logic [5:0]  RUN_POINTS   = 6'd15;
  localparam logic [5:0]  START_POINTS = 6'd20;
  localparam logic [11:0] SCORE_CAP    = 12'd4095;
  localparam logic signed [12:0] SCORE_NONE = -13'sd1;

  // separator bytes
  localparam logic [7:0] SEP_SLASH      = 8'h2F;
  localparam logic [7:0] SEP_UNDERSCORE = 8'h5F;
  localparam logic [7:0] SEP_DASH       = 8'h2D;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // input item
  typedef struct packed {
    logic [1:0] command;
    logic [7:0] char_code;
    logic       last;
  } fss_in_t;

  // result item
  typedef struct packed {
    logic signed [12:0] score;
    logic               matched;
  } fss_out_t;

  // fold ascii upper case to lower case
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic logic is_separator(input logic [7:0] c);
    return (c == SEP_SLASH) || (c == SEP_UNDERSCORE) || (c == SEP_DASH);
  endfunction

endpackage

@@ rtl/fss_query_mem.sv @@
`timescale 1ns / 1ps

module fss_query_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read with write-through on same address
  always_ff @(posedge clk_i) begin
    if (we_i && (waddr_i == raddr_i)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/fss_match_unit.sv @@
`timescale 1ns / 1ps

module fss_match_unit #(
  parameter int QUERY_MAX = 64,
  parameter int AW        = 6,
  parameter int CW        = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  fss_pkg::fss_in_t item_i,
  input  logic [7:0]       qchar_i,
  output logic             mem_we_o,
  output logic [AW-1:0]    mem_waddr_o,
  output logic [7:0]       mem_wdata_o,
  output logic [AW-1:0]    mem_raddr_o,
  output logic             emit_o,
  output fss_pkg::fss_out_t result_o
);

  localparam logic [CW-1:0] QMAX = CW'(QUERY_MAX);

  logic [CW-1:0] len_q, len_d;
  logic [CW-1:0] pos_q, pos_d, pos_hit;
  logic [11:0]   score_q, score_d, score_hit;
  logic          prevm_q, prevm_d;
  logic [7:0]    prevc_q, prevc_d;
  logic          start_q, start_d;
  logic          hit;
  logic [5:0]    inc;
  logic [12:0]   sum;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q   <= '0;
      pos_q   <= '0;
      score_q <= '0;
      prevm_q <= 1'b1;
      prevc_q <= '0;
      start_q <= 1'b1;
    end else begin
      len_q   <= len_d;
      pos_q   <= pos_d;
      score_q <= score_d;
      prevm_q <= prevm_d;
      prevc_q <= prevc_d;
      start_q <= start_d;
    end
  end

  // compare against the prefetched query character
  always_comb begin
    hit = (pos_q < len_q) &&
          (fss_pkg::fold_case(item_i.char_code) == fss_pkg::fold_case(qchar_i));
    inc = fss_pkg::HIT_POINTS;
    if (prevm_q) begin
      inc = inc + fss_pkg::RUN_POINTS;
    end
    if (start_q || fss_pkg::is_separator(prevc_q)) begin
      inc = inc + fss_pkg::START_POINTS;
    end
    sum = {1'b0, score_q} + {7'd0, inc};
    if (!hit) begin
      score_hit = score_q;
      pos_hit   = pos_q;
    end else begin
      score_hit = sum[12] ? fss_pkg::SCORE_CAP : sum[11:0];
      pos_hit   = pos_q + CW'(1);
    end
  end

  // next state and result per command
  always_comb begin
    len_d       = len_q;
    pos_d       = pos_q;
    score_d     = score_q;
    prevm_d     = prevm_q;
    prevc_d     = prevc_q;
    start_d     = start_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = len_q[AW-1:0];
    mem_wdata_o = item_i.char_code;
    emit_o      = 1'b0;
    result_o.score   = {1'b0, score_hit};
    result_o.matched = 1'b1;

    unique case (fss_pkg::fss_cmd_e'(item_i.command))
      fss_pkg::CMD_CLEAR: begin
        if (step_i) begin
          len_d   = '0;
          pos_d   = '0;
          score_d = '0;
          prevm_d = 1'b1;
          prevc_d = '0;
          start_d = 1'b1;
        end
      end
      fss_pkg::CMD_APPEND: begin
        if (step_i && (len_q < QMAX)) begin
          mem_we_o = 1'b1;
          len_d    = len_q + CW'(1);
        end
      end
      fss_pkg::CMD_NAME: begin
        emit_o = item_i.last;
        if (pos_hit < len_q) begin
          result_o.score   = fss_pkg::SCORE_NONE;
          result_o.matched = 1'b0;
        end
        if (step_i) begin
          if (item_i.last) begin
            pos_d   = '0;
            score_d = '0;
            prevm_d = 1'b1;
            prevc_d = '0;
            start_d = 1'b1;
          end else begin
            pos_d   = pos_hit;
            score_d = score_hit;
            prevm_d = hit;
            prevc_d = item_i.char_code;
            start_d = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase

    // prefetch the query character for the next name character
    mem_raddr_o = (pos_d < QMAX) ? pos_d[AW-1:0] : '0;
  end

endmodule

@@ rtl/fuzzy_subsequence_scorer.sv @@
`timescale 1ns / 1ps

// channel   direction  handshake              payload
// in        input      in_valid_i/in_ready_o  in_data_i  (command, char_code, last)
// out       output     out_valid_o/out_ready_i out_data_o (score, matched)
//
// one item per cycle unless a name-ending item meets a full result slot; an item is
// held in the input register, then its result is registered after compare and add
// reset clears the query length and the name state; query bytes are not cleared
// a stalled result holds only items that finish a name; other items keep flowing

module fuzzy_subsequence_scorer #(
  parameter int QUERY_MAX = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  fss_pkg::fss_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fss_pkg::fss_out_t out_data_o
);

  localparam int AW = (QUERY_MAX > 1) ? $clog2(QUERY_MAX) : 1;
  localparam int CW = $clog2(QUERY_MAX + 1);

  logic              in_valid_q;
  fss_pkg::fss_in_t  in_data_q;
  logic              out_valid_q;
  fss_pkg::fss_out_t out_data_q;
  logic              advance;
  logic              emit;
  fss_pkg::fss_out_t result;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [7:0]        mem_wdata;
  logic [AW-1:0]     mem_raddr;
  logic [7:0]        qchar;

  // the held item moves on unless it needs a result slot that is still full
  assign advance    = in_valid_q && (!emit || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_data_q <= in_data_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && emit) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // scoring state and compare
  fss_match_unit #(
    .QUERY_MAX (QUERY_MAX),
    .AW        (AW),
    .CW        (CW)
  ) u_match (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (in_data_q),
    .qchar_i     (qchar),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .emit_o      (emit),
    .result_o    (result)
  );

  // query character store
  fss_query_mem #(
    .DEPTH (QUERY_MAX),
    .AW    (AW)
  ) u_query (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (qchar)
  );

endmodule
